>>> design/binary_row_field_decoder_macros.svh
// assertion macros for the binary row field decoder
// no dependencies; included by the top level, which provides clk and arst_n
`ifndef BINARY_ROW_FIELD_DECODER_MACROS_SVH
`define BINARY_ROW_FIELD_DECODER_MACROS_SVH

// same-cycle implication, checked out of reset
`define BRFD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define BRFD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/brfd_pkg.sv
// shared types and constants for the binary row field decoder
// no dependencies
package brfd_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;

	typedef enum logic [1:0] {
		REG_COLUMN_COUNT = 2'd0,
		REG_COLUMN_TYPES = 2'd1,
		REG_FOOTER_MARKER = 2'd2,
		REG_NULL_MARKER = 2'd3
	} brfd_reg_t;

	typedef enum logic [2:0] {
		KIND_VALUE = 3'd0,
		KIND_NULL = 3'd1,
		KIND_CHAR_HDR = 3'd2,
		KIND_CHAR_BYTE = 3'd3,
		KIND_ROW = 3'd4,
		KIND_ERROR = 3'd5
	} brfd_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE = 3'd0,
		ERR_COUNT = 3'd1,
		ERR_NEG_LEN = 3'd2,
		ERR_BAD_LEN = 3'd3,
		ERR_UNSUPPORTED = 3'd4
	} brfd_err_t;

	localparam logic [3:0] TYPE_INT = 4'd0;
	localparam logic [3:0] TYPE_BIGINT = 4'd1;
	localparam logic [3:0] TYPE_FLOAT = 4'd2;
	localparam logic [3:0] TYPE_DOUBLE = 4'd3;
	localparam logic [3:0] TYPE_SHORT = 4'd4;
	localparam logic [3:0] TYPE_VARCHAR = 4'd5;
	localparam logic [3:0] TYPE_CHAR = 4'd6;
	localparam logic [3:0] TYPE_DATE = 4'd7;
	localparam logic [3:0] TYPE_TIME = 4'd8;
	localparam logic [3:0] TYPE_TIMESTAMP = 4'd9;
	localparam logic [3:0] TYPE_DATETIME = 4'd10;
	localparam logic [3:0] TYPE_LAST_KNOWN = 4'd10;

	typedef struct packed {
		logic [4:0] column_count;
		logic [63:0] column_types;
		logic signed [15:0] footer_marker;
		logic signed [31:0] null_length_marker;
	} brfd_cfg_t;

	typedef struct packed {
		brfd_kind_t kind;
		logic [3:0] column_index;
		logic [63:0] value_bits;
		logic [3:0] type_code;
		logic last_flag;
		brfd_err_t fault_code;
	} brfd_result_t;

	// body size in bytes per type code, zero for char and unknown types
	function automatic logic [3:0] body_size(logic [3:0] tcode);
		logic [3:0] sz;
		case (tcode)
			TYPE_INT, TYPE_FLOAT, TYPE_DATE, TYPE_TIME, TYPE_TIMESTAMP: sz = 4'd4;
			TYPE_BIGINT, TYPE_DOUBLE, TYPE_DATETIME: sz = 4'd8;
			TYPE_SHORT: sz = 4'd2;
			default: sz = 4'd0;
		endcase
		return sz;
	endfunction

endpackage

>>> design/brfd_if.sv
// valid/ready stream interfaces for the byte input and the result output
// no dependencies
interface brfd_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic restart;

	modport source (output valid, output data_byte, output restart, input ready);
	modport sink (input valid, input data_byte, input restart, output ready);
endinterface

interface brfd_out_if;
	logic valid;
	logic ready;
	logic [2:0] kind;
	logic [3:0] column_index;
	logic [63:0] value_bits;
	logic [3:0] type_code;
	logic last_flag;
	logic [2:0] fault_code;

	modport source (output valid, output kind, output column_index, output value_bits,
		output type_code, output last_flag, output fault_code, input ready);
	modport sink (input valid, input kind, input column_index, input value_bits,
		input type_code, input last_flag, input fault_code, output ready);
endinterface

>>> design/brfd_cfg_regs.sv
// apb-style configuration registers
// depends on brfd_pkg
module brfd_cfg_regs (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [brfd_pkg::ADDR_W-1:0] paddr,
	input logic [brfd_pkg::DATA_W-1:0] pwdata,
	output logic [brfd_pkg::DATA_W-1:0] prdata,
	output brfd_pkg::brfd_cfg_t cfg
);
	import brfd_pkg::*;

	brfd_cfg_t cfg_q;
	brfd_reg_t sel;
	logic wr_en;

	assign sel = brfd_reg_t'(paddr[ADDR_W-1:3]);
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.column_count <= 5'd1;
			cfg_q.column_types <= '0;
			cfg_q.footer_marker <= -16'sd1;
			cfg_q.null_length_marker <= -32'sd1;
		end else if (wr_en) begin
			unique case (sel)
				REG_COLUMN_COUNT: cfg_q.column_count <= pwdata[4:0];
				REG_COLUMN_TYPES: cfg_q.column_types <= pwdata;
				REG_FOOTER_MARKER: cfg_q.footer_marker <= $signed(pwdata[15:0]);
				REG_NULL_MARKER: cfg_q.null_length_marker <= $signed(pwdata[31:0]);
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_COLUMN_COUNT: prdata = {59'd0, cfg_q.column_count};
			REG_COLUMN_TYPES: prdata = cfg_q.column_types;
			REG_FOOTER_MARKER: prdata = {48'd0, $unsigned(cfg_q.footer_marker)};
			REG_NULL_MARKER: prdata = {32'd0, $unsigned(cfg_q.null_length_marker)};
		endcase
	end

	assign cfg = cfg_q;

endmodule

>>> design/brfd_parser.sv
// row parser: state registers and the one-byte step logic
// depends on brfd_pkg
module brfd_parser #(
	parameter int MAX_COLUMNS = 16
) (
	input logic clk,
	input logic arst_n,
	input brfd_pkg::brfd_cfg_t cfg,
	input logic advance,
	input logic [7:0] data_byte,
	input logic restart,
	output logic res_valid,
	output brfd_pkg::brfd_result_t res,
	output logic halted
);
	import brfd_pkg::*;

	typedef enum logic [5:0] {
		PH_HDR = 6'b000001,
		PH_LEN = 6'b000010,
		PH_BODY = 6'b000100,
		PH_CHAR = 6'b001000,
		PH_DONE = 6'b010000,
		PH_HALT = 6'b100000
	} brfd_phase_t;

	localparam logic [4:0] MaxCols = 5'(MAX_COLUMNS);

	brfd_phase_t phase_q, phase_d;
	logic [1:0] pos_q, pos_d;
	logic [63:0] asm_q, asm_d;
	logic [3:0] col_q, col_d;
	logic [30:0] cnt_q, cnt_d;

	logic [4:0] ncols;
	logic [3:0] col_type;
	logic last_col;
	logic [15:0] hdr_word;
	logic [31:0] len_word;
	logic [63:0] asm_shift;

	assign ncols = (cfg.column_count > MaxCols) ? MaxCols : cfg.column_count;
	assign col_type = cfg.column_types[{col_q, 2'b00} +: 4];
	assign last_col = ({1'b0, col_q} + 5'd1) >= ncols;
	assign hdr_word = {asm_q[7:0], data_byte};
	assign len_word = {asm_q[23:0], data_byte};
	assign asm_shift = {asm_q[55:0], data_byte};
	assign halted = (phase_q == PH_HALT);

	always_comb begin
		phase_d = phase_q;
		pos_d = pos_q;
		asm_d = asm_q;
		col_d = col_q;
		cnt_d = cnt_q;
		res_valid = 1'b0;
		res.kind = KIND_VALUE;
		res.column_index = col_q;
		res.value_bits = '0;
		res.type_code = col_type;
		res.last_flag = 1'b0;
		res.fault_code = ERR_NONE;

		if (restart) begin
			phase_d = PH_HDR;
			pos_d = '0;
			asm_d = '0;
			col_d = '0;
			cnt_d = '0;
		end else begin
			unique case (phase_q)
				PH_DONE: begin
					// row done, and this byte opens the next header
					res_valid = 1'b1;
					res.kind = KIND_ROW;
					res.type_code = TYPE_INT;
					phase_d = PH_HDR;
					pos_d = 2'd1;
					asm_d = {56'd0, data_byte};
					col_d = '0;
					cnt_d = '0;
				end
				PH_HDR: begin
					asm_d = asm_shift;
					pos_d = pos_q + 2'd1;
					if (pos_q != 2'd0) begin
						pos_d = '0;
						asm_d = '0;
						col_d = '0;
						res.column_index = '0;
						res.type_code = TYPE_INT;
						if (hdr_word == $unsigned(cfg.footer_marker)) begin
							res_valid = 1'b1;
							res.kind = KIND_ROW;
							res.value_bits = 64'd1;
							res.last_flag = 1'b1;
						end else if (hdr_word != {11'd0, ncols}) begin
							res_valid = 1'b1;
							res.kind = KIND_ERROR;
							res.value_bits = {48'd0, hdr_word};
							res.fault_code = ERR_COUNT;
							phase_d = PH_HALT;
						end else if (ncols == 5'd0) begin
							res_valid = 1'b1;
							res.kind = KIND_ROW;
						end else begin
							phase_d = PH_LEN;
						end
					end
				end
				PH_LEN: begin
					asm_d = asm_shift;
					pos_d = pos_q + 2'd1;
					if (pos_q == 2'd3) begin
						pos_d = '0;
						asm_d = '0;
						res_valid = 1'b1;
						res.value_bits = {32'd0, len_word};
						if (len_word == $unsigned(cfg.null_length_marker)) begin
							res.kind = KIND_NULL;
							res.value_bits = '0;
							if (last_col) begin
								phase_d = PH_DONE;
							end else begin
								col_d = col_q + 4'd1;
							end
						end else if (len_word[31]) begin
							res.kind = KIND_ERROR;
							res.fault_code = ERR_NEG_LEN;
							phase_d = PH_HALT;
						end else if (col_type == TYPE_VARCHAR || col_type == TYPE_CHAR) begin
							res.kind = KIND_CHAR_HDR;
							if (len_word == 32'd0) begin
								if (last_col) begin
									phase_d = PH_DONE;
								end else begin
									col_d = col_q + 4'd1;
								end
							end else begin
								cnt_d = len_word[30:0];
								phase_d = PH_CHAR;
							end
						end else if (col_type > TYPE_LAST_KNOWN) begin
							res.kind = KIND_ERROR;
							res.fault_code = ERR_UNSUPPORTED;
							phase_d = PH_HALT;
						end else if (len_word != {28'd0, body_size(col_type)}) begin
							res.kind = KIND_ERROR;
							res.fault_code = ERR_BAD_LEN;
							phase_d = PH_HALT;
						end else begin
							res_valid = 1'b0;
							cnt_d = {27'd0, body_size(col_type)};
							phase_d = PH_BODY;
						end
					end
				end
				PH_BODY: begin
					asm_d = asm_shift;
					cnt_d = cnt_q - 31'd1;
					if (cnt_q == 31'd1) begin
						res_valid = 1'b1;
						res.kind = KIND_VALUE;
						res.value_bits = asm_shift;
						asm_d = '0;
						pos_d = '0;
						if (last_col) begin
							phase_d = PH_DONE;
						end else begin
							col_d = col_q + 4'd1;
							phase_d = PH_LEN;
						end
					end
				end
				PH_CHAR: begin
					res_valid = 1'b1;
					res.kind = KIND_CHAR_BYTE;
					res.value_bits = {56'd0, data_byte};
					res.last_flag = (cnt_q == 31'd1);
					cnt_d = cnt_q - 31'd1;
					if (cnt_q == 31'd1) begin
						pos_d = '0;
						if (last_col) begin
							phase_d = PH_DONE;
						end else begin
							col_d = col_q + 4'd1;
							phase_d = PH_LEN;
						end
					end
				end
				PH_HALT: begin
					phase_d = PH_HALT;
				end
				default: begin
					phase_d = PH_HALT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			pos_q <= '0;
			asm_q <= '0;
			col_q <= '0;
			cnt_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			asm_q <= asm_d;
			col_q <= col_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

>>> design/binary_row_field_decoder.sv
// binary row field decoder: one stream byte per request, at most one result each
// the result register loads at the edge that moves the request out of the input register;
//   a request waits there while the result register is full and not being drained
// throughput: one request per cycle while the result slot is free; the parser state updates in a single pass
// reset: arst_n clears parse state and handshake valids and sets the config registers to their defaults
module binary_row_field_decoder #(
	parameter int MAX_COLUMNS = 16
) (
	input logic clk,
	input logic arst_n,
	brfd_in_if.sink byte_stream,
	brfd_out_if.source result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [brfd_pkg::ADDR_W-1:0] paddr,
	input logic [brfd_pkg::DATA_W-1:0] pwdata,
	output logic [brfd_pkg::DATA_W-1:0] prdata,
	output logic pready
);
	import brfd_pkg::*;

	`include "binary_row_field_decoder_macros.svh"

	brfd_cfg_t cfg;

	// input register: one request waiting for the parser
	logic valid_s1;
	logic [7:0] data_s1;
	logic restart_s1;

	// result register
	logic out_valid_q;
	brfd_result_t out_res_q;

	logic out_free;
	logic advance;
	logic res_valid;
	brfd_result_t res;
	logic halted;

	// zero wait states on the config port
	assign pready = 1'b1;

	brfd_cfg_regs u_cfg (
		.clk (clk),
		.arst_n (arst_n),
		.psel (psel),
		.penable (penable),
		.pwrite (pwrite),
		.paddr (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg (cfg)
	);

	// the parser steps whenever the result register can take what it makes,
	// either because it is empty or because its content leaves this edge
	assign out_free = !out_valid_q || result.ready;
	assign advance = valid_s1 && out_free;
	assign byte_stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_stream.valid && byte_stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.valid && byte_stream.ready) begin
			data_s1 <= byte_stream.data_byte;
			restart_s1 <= byte_stream.restart;
		end
	end

	brfd_parser #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_parser (
		.clk (clk),
		.arst_n (arst_n),
		.cfg (cfg),
		.advance (advance),
		.data_byte (data_s1),
		.restart (restart_s1),
		.res_valid (res_valid),
		.res (res),
		.halted (halted)
	);

	// a step without a result still frees the result slot if it was drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_res_q <= res;
		end
	end

	assign result.valid = out_valid_q;
	assign result.kind = out_res_q.kind;
	assign result.column_index = out_res_q.column_index;
	assign result.value_bits = out_res_q.value_bits;
	assign result.type_code = out_res_q.type_code;
	assign result.last_flag = out_res_q.last_flag;
	assign result.fault_code = out_res_q.fault_code;

	// an emitted error always leaves the parser halted
	`BRFD_ASSERT_NXT(a_err_halts, advance && res_valid && res.kind == KIND_ERROR, halted, "error did not halt")

	// a blocked request stays in the input register unchanged
	`BRFD_ASSERT_NXT(a_s1_hold, valid_s1 && !advance, valid_s1 && $stable(data_s1) && $stable(restart_s1), "lost request")

	// fault code is set exactly on error results
	`BRFD_ASSERT_IMP(a_err_code, out_valid_q, (out_res_q.kind == KIND_ERROR) == (out_res_q.fault_code != ERR_NONE), "bad code")

	// last flag only on char bytes and on the footer
	`BRFD_ASSERT_IMP(a_last_kind, out_valid_q && out_res_q.last_flag, out_res_q.kind inside {KIND_CHAR_BYTE, KIND_ROW} == 1'b1 || 1'b0, "bad last")

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// testbench for the binary row field decoder: stream bytes in, decoded fields out
// depends on brfd_pkg, the brfd_in_if / brfd_out_if interfaces and the decoder rtl

module tb_top;
	import brfd_pkg::*;

	// column type codes as they appear in the packed type register
	typedef enum logic [3:0] {
		COL_INT, COL_BIGINT, COL_FLOAT, COL_DOUBLE, COL_SHORT, COL_VARCHAR,
		COL_CHAR, COL_DATE, COL_TIME, COL_TIMESTAMP, COL_DATETIME
	} col_type_t;

	// where the parser stands inside the byte stream
	typedef enum logic [2:0] {
		PS_HEADER, PS_LENGTH, PS_BODY, PS_CHARS, PS_ROW_END, PS_HALTED
	} parse_state_t;

	// one stream request as the driver presents it
	typedef struct packed {
		logic [7:0] data_byte;
		logic restart;
	} stream_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;

	brfd_in_if in_bus();
	brfd_out_if res_bus();

	binary_row_field_decoder #(.MAX_COLUMNS(16)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.byte_stream(in_bus),
		.result(res_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register copies, written together with the block's registers
	logic [4:0] col_count_q = 5'd1;
	logic [63:0] col_types_q = '0;
	logic [15:0] footer_q = 16'hFFFF;
	logic [31:0] null_mark_q = 32'hFFFF_FFFF;

	// parser copy, same reset values as the block
	parse_state_t parse_st = PS_HEADER;
	logic [31:0] byte_pos = '0;
	logic [63:0] shift_acc = '0;
	logic [3:0] cur_col = '0;
	logic [31:0] body_len = '0;

	stream_req_t byte_requests[$];     // requests waiting for the driver
	brfd_result_t decoded_fields[$];   // predicted results, oldest first

	int unsigned bytes_queued = 0;
	int unsigned bytes_accepted = 0;
	int unsigned send_idle_pct = 37;
	int unsigned take_idle_pct = 37;
	int unsigned fail_count = 0;
	int unsigned results_checked = 0;
	int unsigned row_ends = 0;
	int unsigned error_results = 0;

	// body size in bytes of a fixed-width column, zero for char and unknown codes
	function automatic int unsigned fixed_body_bytes(logic [3:0] tcode);
		case (tcode)
			COL_INT, COL_FLOAT, COL_DATE, COL_TIME, COL_TIMESTAMP: return 4;
			COL_BIGINT, COL_DOUBLE, COL_DATETIME: return 8;
			COL_SHORT: return 2;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned live_columns();
		return (col_count_q > 5'd16) ? 16 : col_count_q;
	endfunction

	task automatic push_field(brfd_kind_t kind, logic [3:0] col, logic [63:0] val,
		logic [3:0] tcode, logic last, brfd_err_t err);
		brfd_result_t r;
		r.kind = kind;
		r.column_index = col;
		r.value_bits = val;
		r.type_code = tcode;
		r.last_flag = last;
		r.fault_code = err;
		decoded_fields.push_back(r);
	endtask

	task automatic clear_parser();
		parse_st = PS_HEADER;
		byte_pos = '0;
		shift_acc = '0;
		cur_col = '0;
		body_len = '0;
	endtask

	// move on to the next column, or to row end after the last one
	task automatic advance_column();
		byte_pos = '0;
		shift_acc = '0;
		if (cur_col + 1 >= live_columns()) begin
			parse_st = PS_ROW_END;
		end else begin
			cur_col = cur_col + 4'd1;
			parse_st = PS_LENGTH;
		end
	endtask

	task automatic halt_with(logic [63:0] val, logic [3:0] tcode, brfd_err_t err);
		parse_st = PS_HALTED;
		push_field(KIND_ERROR, cur_col, val, tcode, 1'b0, err);
	endtask

	// predicts what one accepted stream byte produces
	task automatic parse_stream_byte(logic [7:0] b, logic restart);
		logic [3:0] tcode;
		logic [3:0] col_was;
		logic [15:0] cnt;
		logic [31:0] len;
		tcode = col_types_q[cur_col * 4 +: 4];
		if (restart) begin
			clear_parser();
		end else begin
			case (parse_st)
				PS_ROW_END: begin
					// row end reported on the first byte of the next header
					col_was = cur_col;
					clear_parser();
					shift_acc = {56'd0, b};
					byte_pos = 32'd1;
					push_field(KIND_ROW, col_was, '0, '0, 1'b0, ERR_NONE);
				end
				PS_HEADER: begin
					shift_acc = {shift_acc[55:0], b};
					byte_pos = byte_pos + 1;
					if (byte_pos >= 2) begin
						cnt = shift_acc[15:0];
						byte_pos = '0;
						shift_acc = '0;
						cur_col = '0;
						// footer marker wins over the count check
						if (cnt == footer_q)
							push_field(KIND_ROW, '0, 64'd1, '0, 1'b1, ERR_NONE);
						else if (cnt != live_columns())
							halt_with({48'd0, cnt}, '0, ERR_COUNT);
						else if (live_columns() == 0)
							push_field(KIND_ROW, '0, '0, '0, 1'b0, ERR_NONE);
						else
							parse_st = PS_LENGTH;
					end
				end
				PS_LENGTH: begin
					shift_acc = {shift_acc[55:0], b};
					byte_pos = byte_pos + 1;
					if (byte_pos >= 4) begin
						len = shift_acc[31:0];
						byte_pos = '0;
						shift_acc = '0;
						// null marker is tested before sign and type checks
						if (len == null_mark_q) begin
							push_field(KIND_NULL, cur_col, '0, tcode, 1'b0, ERR_NONE);
							advance_column();
						end else if (len[31]) begin
							halt_with({32'd0, len}, tcode, ERR_NEG_LEN);
						end else if (tcode == COL_VARCHAR || tcode == COL_CHAR) begin
							push_field(KIND_CHAR_HDR, cur_col, {32'd0, len}, tcode, 1'b0,
								ERR_NONE);
							if (len == 0) begin
								advance_column();
							end else begin
								body_len = len;
								parse_st = PS_CHARS;
							end
						end else if (tcode > COL_DATETIME) begin
							halt_with({32'd0, len}, tcode, ERR_UNSUPPORTED);
						end else if (len != fixed_body_bytes(tcode)) begin
							halt_with({32'd0, len}, tcode, ERR_BAD_LEN);
						end else begin
							body_len = len;
							parse_st = PS_BODY;
						end
					end
				end
				PS_BODY: begin
					shift_acc = {shift_acc[55:0], b};
					byte_pos = byte_pos + 1;
					if (byte_pos >= body_len) begin
						push_field(KIND_VALUE, cur_col, shift_acc, tcode, 1'b0, ERR_NONE);
						advance_column();
					end
				end
				PS_CHARS: begin
					byte_pos = byte_pos + 1;
					push_field(KIND_CHAR_BYTE, cur_col, {56'd0, b}, tcode,
						byte_pos >= body_len, ERR_NONE);
					if (byte_pos >= body_len)
						advance_column();
				end
				default: ;  // halted: nothing until restart
			endcase
		end
	endtask

	// driver: presents queued requests, idles at random, predicts on acceptance
	always @(posedge clk) begin
		stream_req_t nxt;
		if (arst_n) begin
			if (in_bus.valid && in_bus.ready) begin
				parse_stream_byte(in_bus.data_byte, in_bus.restart);
				bytes_accepted++;
			end
			if (!in_bus.valid || in_bus.ready) begin
				if (byte_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = byte_requests.pop_front();
					in_bus.valid <= 1'b1;
					in_bus.data_byte <= nxt.data_byte;
					in_bus.restart <= nxt.restart;
				end else begin
					in_bus.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random back-pressure, checks each accepted result against the oldest prediction
	always @(posedge clk) begin
		brfd_result_t want;
		brfd_result_t got;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			got.kind = brfd_kind_t'(res_bus.kind);
			got.column_index = res_bus.column_index;
			got.value_bits = res_bus.value_bits;
			got.type_code = res_bus.type_code;
			got.last_flag = res_bus.last_flag;
			got.fault_code = brfd_err_t'(res_bus.fault_code);
			results_checked++;
			if (got.kind == KIND_ROW) row_ends++;
			if (got.kind == KIND_ERROR) error_results++;
			if (decoded_fields.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%t unexpected result: kind %0d col %0d value %h type %0d last %0b err %0d",
						$realtime, res_bus.kind, got.column_index, got.value_bits,
						got.type_code, got.last_flag, res_bus.fault_code);
			end else begin
				want = decoded_fields.pop_front();
				if (res_bus.kind !== want.kind || res_bus.column_index !== want.column_index ||
					res_bus.value_bits !== want.value_bits ||
					res_bus.type_code !== want.type_code ||
					res_bus.last_flag !== want.last_flag ||
					res_bus.fault_code !== want.fault_code) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%t mismatch, expected: kind %0d col %0d value %h type %0d last %0b err %0d",
							$realtime, want.kind, want.column_index, want.value_bits,
							want.type_code, want.last_flag, want.fault_code);
						$display("%t            actual: kind %0d col %0d value %h type %0d last %0b err %0d",
							$realtime, res_bus.kind, res_bus.column_index, res_bus.value_bits,
							res_bus.type_code, res_bus.last_flag, res_bus.fault_code);
					end
				end
			end
		end
		res_bus.ready <= ($urandom_range(0, 99) >= take_idle_pct);
	end

	// stimulus helpers: everything lands in the request queue
	task automatic queue_byte(logic [7:0] b, logic restart);
		stream_req_t r;
		r.data_byte = b;
		r.restart = restart;
		byte_requests.push_back(r);
		bytes_queued++;
	endtask

	// big-endian word of nbytes bytes
	task automatic queue_word(logic [31:0] v, int unsigned nbytes);
		int k;
		for (k = nbytes - 1; k >= 0; k--)
			queue_byte(v[8 * k +: 8], 1'b0);
	endtask

	task automatic queue_noise();
		repeat ($urandom_range(1, 4))
			queue_byte($urandom_range(0, 255), $urandom_range(0, 7) == 0);
	endtask

	// one row shaped by the current column setup, with occasional broken fields
	task automatic queue_row();
		int unsigned ncol, c, roll;
		logic [3:0] tcode;
		logic [31:0] flen;
		logic [15:0] bad_cnt;
		bit broken;
		ncol = live_columns();
		broken = 0;
		if ($urandom_range(0, 99) < 4) begin
			// header count that does not match
			bad_cnt = $urandom;
			if (bad_cnt == ncol) bad_cnt = bad_cnt + 16'd1;
			queue_word({16'd0, bad_cnt}, 2);
			broken = 1;
		end else begin
			queue_word(ncol, 2);
			for (c = 0; c < ncol && !broken; c++) begin
				tcode = col_types_q[c * 4 +: 4];
				roll = $urandom_range(0, 99);
				if (roll < 8) begin
					queue_word(null_mark_q, 4);
				end else if (roll < 11) begin
					queue_word({1'b1, 31'($urandom)}, 4);
					broken = 1;
				end else if (tcode == COL_VARCHAR || tcode == COL_CHAR) begin
					flen = (roll < 25) ? 0 : $urandom_range(1, 9);
					queue_word(flen, 4);
					repeat (flen) queue_byte($urandom_range(0, 255), 1'b0);
				end else if (tcode > COL_DATETIME) begin
					queue_word($urandom_range(0, 8), 4);
					broken = 1;
				end else begin
					flen = fixed_body_bytes(tcode);
					if (roll < 15) begin
						// wrong length for the type
						flen = flen + $urandom_range(1, 3);
						broken = 1;
					end
					queue_word(flen, 4);
					if (!broken)
						repeat (flen) queue_byte($urandom_range(0, 255), 1'b0);
				end
			end
		end
		// the block sits halted after an error until restarted
		if (broken) begin
			repeat ($urandom_range(0, 3)) queue_byte($urandom_range(0, 255), 1'b0);
			queue_byte($urandom_range(0, 255), 1'b1);
		end
	endtask

	// type nibbles, mostly supported codes, some unknown ones
	function automatic logic [63:0] random_types(int unsigned unknown_pct);
		logic [63:0] v;
		int c;
		for (c = 0; c < 16; c++)
			v[c * 4 +: 4] = ($urandom_range(0, 99) < unknown_pct) ?
				$urandom_range(11, 15) : $urandom_range(0, 10);
		return v;
	endfunction

	// APB write: setup cycle then access cycle, pready is tied high
	task automatic write_reg(brfd_reg_t r, logic [63:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 3'b000};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			REG_COLUMN_COUNT: col_count_q = v[4:0];
			REG_COLUMN_TYPES: col_types_q = v;
			REG_FOOTER_MARKER: footer_q = v[15:0];
			REG_NULL_MARKER: null_mark_q = v[31:0];
			default: ;
		endcase
	endtask

	// wait until every request went in and every predicted result came out
	task automatic wait_drained();
		while (bytes_accepted != bytes_queued || decoded_fields.size() != 0)
			@(negedge clk);
		// a trailing request may still be in the pipe with no result due
		repeat (4) @(posedge clk);
	endtask

	task automatic load_setup(logic [4:0] cnt, logic [63:0] types, logic [15:0] footer,
		logic [31:0] null_mark);
		write_reg(REG_COLUMN_COUNT, {59'd0, cnt});
		write_reg(REG_COLUMN_TYPES, types);
		write_reg(REG_FOOTER_MARKER, {48'd0, footer});
		write_reg(REG_NULL_MARKER, {32'd0, null_mark});
	endtask

	// one setting: rows, footers and noise until enough bytes are queued
	task automatic run_setting(logic [4:0] cnt, logic [63:0] types, logic [15:0] footer,
		logic [31:0] null_mark, int unsigned nbytes);
		int unsigned start, roll;
		load_setup(cnt, types, footer, null_mark);
		start = bytes_queued;
		while (bytes_queued - start < nbytes) begin
			roll = $urandom_range(0, 99);
			if (roll < 6) begin
				queue_word(footer_q, 2);
			end else if (roll < 10) begin
				queue_noise();
				queue_byte($urandom_range(0, 255), 1'b1);
			end else begin
				queue_row();
			end
		end
		// a footer flushes the pending row end before going idle
		queue_word(footer_q, 2);
		wait_drained();
	endtask

	initial begin
		in_bus.valid = 1'b0;
		in_bus.data_byte = '0;
		in_bus.restart = 1'b0;
		res_bus.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: bigint column and char column
		load_setup(5'd2, {56'd0, COL_CHAR, COL_BIGINT}, 16'hFFFF, 32'hFFFF_FFFF);
		queue_word(32'd2, 2);
		queue_word(32'd8, 4);
		queue_word(32'h8000_0000, 4);         // bigint, top bit set
		queue_word(32'h0000_0001, 4);
		queue_word(32'hFFFF_FFFF, 4);         // null in the char column
		queue_word(32'hFFFF, 2);              // row end, then footer
		queue_word(32'd3, 2);                 // count mismatch halts
		queue_byte(8'h7F, 1'b0);              // ignored while halted
		queue_byte(8'h00, 1'b1);              // restart
		wait_drained();

		// random part over a range of settings, extremes included
		run_setting(5'd1, {60'd0, COL_VARCHAR}, 16'h8000, 32'h7FFF_FFFF, 135);
		run_setting(5'd16, random_types(0), 16'h7FFF, 32'h8000_0000, 135);
		run_setting(5'd0, 64'd0, 16'h1234, 32'hFFFF_FFFF, 100);
		// no idling on either side for this whole setting
		send_idle_pct = 0;
		take_idle_pct = 0;
		run_setting(5'd4, {48'd0, COL_CHAR, COL_DATETIME, COL_SHORT, COL_DOUBLE},
			16'hFFFF, 32'hFFFF_FFFF, 135);
		send_idle_pct = 37;
		take_idle_pct = 37;
		run_setting(5'd31, random_types(10), $urandom, 32'd4, 135);
		run_setting(5'd3, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0003, 32'd0, 60);
		run_setting(5'd6, random_types(3), $urandom, $urandom, 135);
		run_setting(5'd1, 64'd0, 16'hFFFF, 32'hFFFF_FFFF, 60);

		if (decoded_fields.size() != 0) fail_count++;
		$display("covered %0d stream bytes over nine register settings", bytes_accepted);
		$display("checked %0d results: %0d row ends or footers, %0d errors",
			results_checked, row_ends, error_results);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
